FILE: rtl/core/dcsm_pkg.sv
`default_nettype none

package dcsm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned KELVIN_W = 17;
  localparam int unsigned SUM_W    = 19;

  // 273.15 K in 1/128 K, rounded to nearest
  localparam logic [SUM_W-1:0] KELVIN_OFFSET = SUM_W'(34963);
  localparam logic [KELVIN_W-1:0] KELVIN_MAX = '1;

  typedef logic [KELVIN_W-1:0] kelvin_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_COUNT  = 3'b010,
    ST_SELECT = 3'b100
  } state_t;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic ch;      // channel whose window moves
    logic insert;  // shift a new sample in, clear rank counts
    logic rotate;  // pass value and counts to the next cell
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/dual_channel_sliding_median_unit.sv
`default_nettype none

// Channel | Valid      | Stall      | Payload
// --------+------------+------------+------------------------------------------
// in      | in_valid   | in_stall   | in_sensor_channel, in_celsius_sample
// out     | out_valid  | out_stall  | out_channel_echo, out_median_kelvin
// cfg     | cfg_wr_en  | -          | cfg_wr_data (second channel offset)
//
// A request shifts the sample into its channel's chain, rotates the values
// around the whole cell chain so that every entry is ranked, and then picks
// the median into the output register.
// in_stall is high until the median is loaded into the output register; a new
// request is taken while the previous result still waits at the output.
// Synchronous reset clears all windows to zero kelvin and the offset to zero.

module dual_channel_sliding_median_unit #(
  parameter int unsigned WINDOW = 5
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_sensor_channel,
  input  wire logic signed [dcsm_pkg::SAMPLE_W-1:0]  in_celsius_sample,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_channel_echo,
  output logic [dcsm_pkg::KELVIN_W-1:0]               out_median_kelvin,
  input  wire logic                                   cfg_wr_en,
  input  wire logic signed [dcsm_pkg::OFFSET_W-1:0]  cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned ROT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] MID      = CNT_W'(WINDOW / 2);
  localparam logic [ROT_W-1:0] ROT_LAST = ROT_W'(WINDOW - 1);

  dcsm_pkg::state_t state_r, state_nxt;
  logic [ROT_W-1:0] rot_cnt_r, rot_cnt_nxt;
  logic             ch_r;
  logic signed [dcsm_pkg::OFFSET_W-1:0] offset_r;
  logic             out_valid_r;
  logic             out_ch_r;
  dcsm_pkg::kelvin_t out_med_r;

  logic              in_accept;
  logic              out_load;
  dcsm_pkg::kelvin_t kelvin;
  dcsm_pkg::kelvin_t median;
  dcsm_pkg::cell_ctl_t ctl;

  dcsm_pkg::kelvin_t cur_val [WINDOW];
  logic [CNT_W-1:0]  cur_lt  [WINDOW];
  logic [CNT_W-1:0]  cur_le  [WINDOW];

  assign in_stall  = (state_r != dcsm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == dcsm_pkg::ST_SELECT) && (!out_valid_r || !out_stall);

  dcsm_conv u_conv (
    .ch      (in_sensor_channel),
    .celsius (in_celsius_sample),
    .offset  (offset_r),
    .kelvin  (kelvin)
  );

  always_comb begin
    ctl.ch     = (state_r == dcsm_pkg::ST_IDLE) ? in_sensor_channel : ch_r;
    ctl.insert = in_accept;
    ctl.rotate = (state_r == dcsm_pkg::ST_COUNT);
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      dcsm_cell #(.CNT_W(CNT_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .prev_val (ctl.insert ? kelvin : cur_val[WINDOW-1]),
        .prev_lt  (cur_lt[WINDOW-1]),
        .prev_le  (cur_le[WINDOW-1]),
        .bcast    (cur_val[WINDOW-1]),
        .cur_val  (cur_val[i]),
        .cur_lt   (cur_lt[i]),
        .cur_le   (cur_le[i])
      );
    end else begin : g_body
      dcsm_cell #(.CNT_W(CNT_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .prev_val (cur_val[i-1]),
        .prev_lt  (cur_lt[i-1]),
        .prev_le  (cur_le[i-1]),
        .bcast    (cur_val[WINDOW-1]),
        .cur_val  (cur_val[i]),
        .cur_lt   (cur_lt[i]),
        .cur_le   (cur_le[i])
      );
    end
  end

  // entry v is the median when (#less than v) <= MID < (#less or equal v);
  // every entry that qualifies holds the same value
  always_comb begin
    median = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (cur_lt[i] <= MID && MID < cur_le[i]) begin
        median = cur_val[i];
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rot_cnt_nxt = rot_cnt_r;
    unique case (state_r)
      dcsm_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt   = dcsm_pkg::ST_COUNT;
          rot_cnt_nxt = '0;
        end
      end
      dcsm_pkg::ST_COUNT: begin
        if (rot_cnt_r == ROT_LAST) begin
          state_nxt   = dcsm_pkg::ST_SELECT;
          rot_cnt_nxt = '0;
        end else begin
          rot_cnt_nxt = rot_cnt_r + 1'b1;
        end
      end
      dcsm_pkg::ST_SELECT: begin
        if (out_load) begin
          state_nxt = dcsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt   = dcsm_pkg::ST_IDLE;
        rot_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcsm_pkg::ST_IDLE;
      rot_cnt_r   <= '0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rot_cnt_r <= rot_cnt_nxt;
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      priority if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch_r <= in_sensor_channel;
    end
    if (out_load) begin
      out_ch_r  <= ch_r;
      out_med_r <= median;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_echo  = out_ch_r;
  assign out_median_kelvin = out_med_r;

endmodule

`default_nettype wire

FILE: rtl/core/dcsm_conv.sv
`default_nettype none

module dcsm_conv (
  input  wire logic                                   ch,
  input  wire logic signed [dcsm_pkg::SAMPLE_W-1:0]  celsius,
  input  wire logic signed [dcsm_pkg::OFFSET_W-1:0]  offset,
  output dcsm_pkg::kelvin_t                           kelvin
);

  logic [dcsm_pkg::SUM_W-1:0] sample_ext;
  logic [dcsm_pkg::SUM_W-1:0] offset_ext;
  logic [dcsm_pkg::SUM_W-1:0] sum;

  assign sample_ext = {{(dcsm_pkg::SUM_W - dcsm_pkg::SAMPLE_W){celsius[dcsm_pkg::SAMPLE_W-1]}},
                       celsius};
  assign offset_ext = ch ? {{(dcsm_pkg::SUM_W - dcsm_pkg::OFFSET_W){offset[dcsm_pkg::OFFSET_W-1]}},
                            offset}
                         : '0;
  assign sum = sample_ext + dcsm_pkg::KELVIN_OFFSET + offset_ext;

  // clamp to 0 .. KELVIN_MAX
  always_comb begin
    priority if (sum[dcsm_pkg::SUM_W-1]) begin
      kelvin = '0;
    end else if (sum[dcsm_pkg::SUM_W-2]) begin
      kelvin = dcsm_pkg::KELVIN_MAX;
    end else begin
      kelvin = sum[dcsm_pkg::KELVIN_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dcsm_cell.sv
`default_nettype none

module dcsm_cell #(
  parameter int unsigned CNT_W = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dcsm_pkg::cell_ctl_t   ctl,
  input  wire dcsm_pkg::kelvin_t     prev_val,
  input  wire logic [CNT_W-1:0]      prev_lt,
  input  wire logic [CNT_W-1:0]      prev_le,
  input  wire dcsm_pkg::kelvin_t     bcast,
  output dcsm_pkg::kelvin_t          cur_val,
  output logic [CNT_W-1:0]           cur_lt,
  output logic [CNT_W-1:0]           cur_le
);

  dcsm_pkg::kelvin_t [1:0] val_r, val_nxt;
  logic [CNT_W-1:0]        lt_r, lt_nxt;
  logic [CNT_W-1:0]        le_r, le_nxt;

  always_comb begin
    val_nxt = val_r;
    lt_nxt  = lt_r;
    le_nxt  = le_r;
    if (ctl.insert) begin
      val_nxt[ctl.ch] = prev_val;
      lt_nxt          = '0;
      le_nxt          = '0;
    end else if (ctl.rotate) begin
      // counts travel with the value; compare against the value at the chain end
      val_nxt[ctl.ch] = prev_val;
      lt_nxt = prev_lt + {{(CNT_W-1){1'b0}}, (bcast <  prev_val)};
      le_nxt = prev_le + {{(CNT_W-1){1'b0}}, (bcast <= prev_val)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      lt_r  <= '0;
      le_r  <= '0;
    end else begin
      val_r <= val_nxt;
      lt_r  <= lt_nxt;
      le_r  <= le_nxt;
    end
  end

  assign cur_val = val_r[ctl.ch];
  assign cur_lt  = lt_r;
  assign cur_le  = le_r;

endmodule

`default_nettype wire
